FILE: src/point_rotate_project_macros.svh
// assertion macros used by the checker file
`ifndef POINT_ROTATE_PROJECT_MACROS_SVH
`define POINT_ROTATE_PROJECT_MACROS_SVH

// plain check, sampled on the rising clock, off during reset
`define PRP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("point_rotate_project check failed");

// implication check, antecedent then consequent on the same edge
`define PRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_rotate_project implication failed");

`endif

FILE: src/ptrot_pkg.sv
// ----------------------------------------------------------------------------
// ptrot_pkg
// shared types, widths and the sine table generator of the rotate/project
// pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptrot_pkg;

    localparam int DEF_SINE_TABLE_ENTRIES = 1024;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [15:0] ONE_Q14 = 16'd16384;

    // register indexes
    localparam logic [7:0] REG_EYE_DISTANCE = 8'd0;
    localparam logic [7:0] REG_PIXEL_SCALE  = 8'd1;
    localparam logic [7:0] REG_OFFSET_X     = 8'd2;
    localparam logic [7:0] REG_OFFSET_Y     = 8'd3;

    localparam logic [14:0] RST_EYE_DISTANCE = 15'd8192;
    localparam logic [11:0] RST_PIXEL_SCALE  = 12'd200;
    localparam logic [11:0] RST_OFFSET_X     = 12'd320;
    localparam logic [11:0] RST_OFFSET_Y     = 12'd240;

    // internal widths
    localparam int CW  = 18;    // rotated coordinate, signed
    localparam int DNW = 19;    // denominator, signed
    localparam int DW  = 19;    // divisor 2*den, unsigned
    localparam int NW  = 32;    // dividend 2*|num|+den, unsigned
    localparam int QW  = 17;    // quotient bits before saturation
    localparam int DIV_TAG_W = 2;

    // start accepted to done strobe, in cycles
    localparam int PIPE_LATENCY = 11 + QW;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
        logic        [15:0] angle_phase;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               behind_viewer;
    } pixel_t;

    // taylor series of sin through x^17, unsigned q30, result rounded to q14
    function automatic logic [15:0] sine_taylor(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] q;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = '0;
        for (int i = 0; i < 8; i++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * i + 2) * (2 * i + 3));
            if (i % 2 == 1)
                pos = pos + term;
            else
                neg = neg + term;
        end
        q = ((pos - neg) + 64'd32768) >> 16;
        if (q > 64'(ONE_Q14))
            q = 64'(ONE_Q14);
        return q[15:0];
    endfunction

endpackage

FILE: src/ptrot_sincos.sv
// ----------------------------------------------------------------------------
// ptrot_sincos
// quarter-wave sine table, registered sine and cosine of one phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptrot_sincos
    import ptrot_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = DEF_SINE_TABLE_ENTRIES
)
(
    input  logic               clk,
    input  logic [15:0]        phase,
    output logic signed [15:0] sin_reg,
    output logic signed [15:0] cos_reg
);

    localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PW = 14 + IW;

    logic [15:0] sine_rom [SINE_TABLE_ENTRIES + 1];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++)
    begin : g_tab
        localparam logic [63:0] ANGLE = (PI_HALF_Q30 * 64'(k)) / SINE_TABLE_ENTRIES;
        assign sine_rom[k] = sine_taylor(ANGLE);
    end

    logic [15:0]        cos_phase;
    logic [IW-1:0]      sin_addr;
    logic [IW-1:0]      cos_addr;
    logic signed [15:0] sin_next;
    logic signed [15:0] cos_next;

    function automatic logic [IW-1:0] quad_addr(input logic [15:0] p);
        logic [PW-1:0] prod;
        logic [IW-1:0] idx;
        prod = PW'(p[13:0]) * PW'(SINE_TABLE_ENTRIES);
        idx  = prod[PW-1:14];
        return p[14] ? IW'(SINE_TABLE_ENTRIES) - idx : idx;
    endfunction

    assign cos_phase = phase + 16'd16384;
    assign sin_addr  = quad_addr(phase);
    assign cos_addr  = quad_addr(cos_phase);

    always_comb
    begin
        sin_next = phase[15] ? -$signed(sine_rom[sin_addr]) : $signed(sine_rom[sin_addr]);
        cos_next = cos_phase[15] ? -$signed(sine_rom[cos_addr])
                                 : $signed(sine_rom[cos_addr]);
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

endmodule

FILE: src/ptrot_div.sv
// ----------------------------------------------------------------------------
// ptrot_div
// pipelined restoring divider, one quotient bit per stage, with a tag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptrot_div
    import ptrot_pkg::*;
(
    input  logic                 clk,
    input  logic [NW-1:0]        dividend,
    input  logic [DW-1:0]        divisor,
    input  logic [DIV_TAG_W-1:0] tag_in,
    output logic [QW-1:0]        quot,
    output logic [DIV_TAG_W-1:0] tag_out
);

    // dividend is known to be below divisor * 2^QW
    logic [DW-1:0]        rem_reg  [QW+1];
    logic [QW-1:0]        low_reg  [QW+1];
    logic [QW-1:0]        quot_reg [QW+1];
    logic [DW-1:0]        dsr_reg  [QW+1];
    logic [DIV_TAG_W-1:0] tag_reg  [QW+1];

    assign rem_reg[0]  = DW'(dividend[NW-1:QW]);
    assign low_reg[0]  = dividend[QW-1:0];
    assign quot_reg[0] = '0;
    assign dsr_reg[0]  = divisor;
    assign tag_reg[0]  = tag_in;

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW:0]   trial;
        logic          take;
        logic [DW-1:0] rem_next;

        assign trial    = {rem_reg[s], low_reg[s][QW-1]};
        assign take     = trial >= {1'b0, dsr_reg[s]};
        assign rem_next = take ? DW'(trial - {1'b0, dsr_reg[s]}) : trial[DW-1:0];

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= rem_next;
            low_reg[s+1]  <= {low_reg[s][QW-2:0], 1'b0};
            quot_reg[s+1] <= {quot_reg[s][QW-2:0], take};
            dsr_reg[s+1]  <= dsr_reg[s];
            tag_reg[s+1]  <= tag_reg[s];
        end
    end

    assign quot    = quot_reg[QW];
    assign tag_out = tag_reg[QW];

endmodule

FILE: src/point_rotate_project.sv
// ----------------------------------------------------------------------------
// point_rotate_project
// rotates a vertex about x, y and z by one angle, then projects it in
// perspective onto the screen with rounding and saturation
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+----------------------------------
//  vertex    | start, busy (always 0)  | vertex_t: x, y, z, angle_phase
//  result    | done strobe, no stall   | pixel_t: screen_x/y, behind_viewer
//  config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
//  one vertex per clock; a result follows its start transaction through the
//  pipeline stages, the 17 stages of the divider and the output register
//  reset clears the valid line and loads the register defaults
//  there is no stall anywhere: busy stays low and done is a one-cycle strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_rotate_project
    import ptrot_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = DEF_SINE_TABLE_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  vertex_t     vertex,
    output logic        done,
    output pixel_t      result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // valid line: stages 0..9, divider, output
    localparam int NSTG = 11 + QW;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    logic [14:0] eye_distance_reg;
    logic [11:0] pixel_scale_reg;
    logic [11:0] offset_x_reg;
    logic [11:0] offset_y_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration transactions, out of range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_distance_reg <= RST_EYE_DISTANCE;
            pixel_scale_reg  <= RST_PIXEL_SCALE;
            offset_x_reg     <= RST_OFFSET_X;
            offset_y_reg     <= RST_OFFSET_Y;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EYE_DISTANCE: eye_distance_reg <= cfg_data[14:0];
                REG_PIXEL_SCALE:  pixel_scale_reg  <= cfg_data[11:0];
                REG_OFFSET_X:     offset_x_reg     <= cfg_data[11:0];
                REG_OFFSET_Y:     offset_y_reg     <= cfg_data[11:0];
                default:          ;
            endcase
        end
    end

    // valid bits travel with the data
    assign vld_next = {vld_reg[NSTG-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // stage 0: input register
    vertex_t s0_reg;
    always_ff @(posedge clk)
    begin
        s0_reg <= vertex;
    end

    // stage 1: sine and cosine lookup
    logic signed [15:0] s1_sin;
    logic signed [15:0] s1_cos;
    logic signed [15:0] s1_x_reg, s1_y_reg, s1_z_reg;

    ptrot_sincos #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_sincos (
        .clk     (clk),
        .phase   (s0_reg.angle_phase),
        .sin_reg (s1_sin),
        .cos_reg (s1_cos)
    );

    always_ff @(posedge clk)
    begin
        s1_x_reg <= s0_reg.vertex_x;
        s1_y_reg <= s0_reg.vertex_y;
        s1_z_reg <= s0_reg.vertex_z;
    end

    // round half up from q26 to q12
    function automatic logic signed [CW-1:0] round_q14(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (v + 36'sd8192) >>> 14;
        return t[CW-1:0];
    endfunction

    // stage 2: products of the x rotation
    logic signed [31:0] s2_cy_reg, s2_sz_reg, s2_sy_reg, s2_cz_reg;
    logic signed [15:0] s2_x_reg, s2_sin_reg, s2_cos_reg;
    always_ff @(posedge clk)
    begin
        s2_cy_reg  <= s1_cos * s1_y_reg;
        s2_sz_reg  <= s1_sin * s1_z_reg;
        s2_sy_reg  <= s1_sin * s1_y_reg;
        s2_cz_reg  <= s1_cos * s1_z_reg;
        s2_x_reg   <= s1_x_reg;
        s2_sin_reg <= s1_sin;
        s2_cos_reg <= s1_cos;
    end

    // stage 3: y1, z1
    logic signed [CW-1:0] s3_y1_reg, s3_z1_reg;
    logic signed [15:0]   s3_x_reg, s3_sin_reg, s3_cos_reg;
    always_ff @(posedge clk)
    begin
        s3_y1_reg  <= round_q14(36'(s2_cy_reg) - 36'(s2_sz_reg));
        s3_z1_reg  <= round_q14(36'(s2_sy_reg) + 36'(s2_cz_reg));
        s3_x_reg   <= s2_x_reg;
        s3_sin_reg <= s2_sin_reg;
        s3_cos_reg <= s2_cos_reg;
    end

    // stage 4: products of the y rotation
    logic signed [33:0]   s4_cx_reg, s4_sz1_reg, s4_sx_reg, s4_cz1_reg;
    logic signed [CW-1:0] s4_y1_reg;
    logic signed [15:0]   s4_sin_reg, s4_cos_reg;
    always_ff @(posedge clk)
    begin
        s4_cx_reg  <= 34'(s3_cos_reg * s3_x_reg);
        s4_sz1_reg <= s3_sin_reg * s3_z1_reg;
        s4_sx_reg  <= 34'(s3_sin_reg * s3_x_reg);
        s4_cz1_reg <= s3_cos_reg * s3_z1_reg;
        s4_y1_reg  <= s3_y1_reg;
        s4_sin_reg <= s3_sin_reg;
        s4_cos_reg <= s3_cos_reg;
    end

    // stage 5: x2, z2
    logic signed [CW-1:0] s5_x2_reg, s5_z2_reg, s5_y1_reg;
    logic signed [15:0]   s5_sin_reg, s5_cos_reg;
    always_ff @(posedge clk)
    begin
        s5_x2_reg  <= round_q14(36'(s4_cx_reg) - 36'(s4_sz1_reg));
        s5_z2_reg  <= round_q14(36'(s4_sx_reg) + 36'(s4_cz1_reg));
        s5_y1_reg  <= s4_y1_reg;
        s5_sin_reg <= s4_sin_reg;
        s5_cos_reg <= s4_cos_reg;
    end

    // stage 6: products of the z rotation
    logic signed [33:0]   s6_cx2_reg, s6_sy1_reg, s6_sx2_reg, s6_cy1_reg;
    logic signed [CW-1:0] s6_z2_reg;
    always_ff @(posedge clk)
    begin
        s6_cx2_reg <= s5_cos_reg * s5_x2_reg;
        s6_sy1_reg <= s5_sin_reg * s5_y1_reg;
        s6_sx2_reg <= s5_sin_reg * s5_x2_reg;
        s6_cy1_reg <= s5_cos_reg * s5_y1_reg;
        s6_z2_reg  <= s5_z2_reg;
    end

    // stage 7: x3, y3 and the denominator
    logic signed [CW-1:0]  s7_x3_reg, s7_y3_reg;
    logic signed [DNW-1:0] s7_den_reg;
    always_ff @(posedge clk)
    begin
        s7_x3_reg  <= round_q14(36'(s6_cx2_reg) - 36'(s6_sy1_reg));
        s7_y3_reg  <= round_q14(36'(s6_sx2_reg) + 36'(s6_cy1_reg));
        s7_den_reg <= $signed({4'b0, eye_distance_reg}) - DNW'(s6_z2_reg);
    end

    // stage 8: numerators and the behind flag
    logic signed [30:0]    s8_nx_reg, s8_ny_reg;
    logic signed [DNW-1:0] s8_den_reg;
    logic                  s8_behind_reg;
    always_ff @(posedge clk)
    begin
        s8_nx_reg     <= s7_x3_reg * $signed({1'b0, pixel_scale_reg});
        s8_ny_reg     <= s7_y3_reg * $signed({1'b0, pixel_scale_reg});
        s8_den_reg    <= s7_den_reg;
        s8_behind_reg <= (s7_den_reg <= 0);
    end

    // stage 9: dividend 2|num|+den, divisor 2den, overflow check
    logic [29:0]   s8_mx, s8_my;
    logic [DW-1:0] s8_dsr;
    logic [NW-1:0] s8_ndx, s8_ndy;

    assign s8_mx  = s8_nx_reg[30] ? 30'(-s8_nx_reg) : s8_nx_reg[29:0];
    assign s8_my  = s8_ny_reg[30] ? 30'(-s8_ny_reg) : s8_ny_reg[29:0];
    // a denominator behind the viewer is replaced by one, its result is discarded
    assign s8_dsr = s8_behind_reg ? DW'(2) : {s8_den_reg[DW-2:0], 1'b0};
    assign s8_ndx = {1'b0, s8_mx, 1'b0} + NW'(s8_dsr[DW-1:1]);
    assign s8_ndy = {1'b0, s8_my, 1'b0} + NW'(s8_dsr[DW-1:1]);

    logic [NW-1:0] s9_ndx_reg, s9_ndy_reg;
    logic [DW-1:0] s9_dsr_reg;
    logic          s9_bigx_reg, s9_bigy_reg;
    logic          s9_negx_reg, s9_negy_reg;
    always_ff @(posedge clk)
    begin
        s9_ndx_reg  <= s8_ndx;
        s9_ndy_reg  <= s8_ndy;
        s9_dsr_reg  <= s8_dsr;
        s9_bigx_reg <= {4'b0, s8_ndx} >= {s8_dsr, QW'(0)};
        s9_bigy_reg <= {4'b0, s8_ndy} >= {s8_dsr, QW'(0)};
        s9_negx_reg <= s8_nx_reg[30];
        s9_negy_reg <= s8_ny_reg[30];
    end

    // behind flag rides alongside stage 9 and the divider
    logic [QW:0] behind_line_reg;
    always_ff @(posedge clk)
    begin
        behind_line_reg <= {behind_line_reg[QW-1:0], s8_behind_reg};
    end

    // divider lanes, the tag carries sign and overflow
    logic [QW-1:0]        qx, qy;
    logic [DIV_TAG_W-1:0] tagx, tagy;
    logic [NW-1:0]        divx_in, divy_in;

    // an overflowing dividend is zeroed, the lane output is then forced
    assign divx_in = s9_bigx_reg ? '0 : s9_ndx_reg;
    assign divy_in = s9_bigy_reg ? '0 : s9_ndy_reg;

    ptrot_div u_div_x (
        .clk      (clk),
        .dividend (divx_in),
        .divisor  (s9_dsr_reg),
        .tag_in   ({s9_negx_reg, s9_bigx_reg}),
        .quot     (qx),
        .tag_out  (tagx)
    );

    ptrot_div u_div_y (
        .clk      (clk),
        .dividend (divy_in),
        .divisor  (s9_dsr_reg),
        .tag_in   ({s9_negy_reg, s9_bigy_reg}),
        .quot     (qy),
        .tag_out  (tagy)
    );

    // sign, offset and saturation to 16 bits
    function automatic logic signed [15:0] finish(input logic [QW-1:0] q,
                                                  input logic [DIV_TAG_W-1:0] tag,
                                                  input logic [11:0] offset);
        logic signed [QW+2:0] sum;
        logic signed [15:0]   r;
        sum = (tag[1] ? -$signed({2'b0, q}) : $signed({2'b0, q}))
              + $signed({(QW - 10)'(0), offset});
        priority if (tag[0])
            r = tag[1] ? 16'sh8000 : 16'sh7fff;
        else if (sum > 32767)
            r = 16'sh7fff;
        else if (sum < -32768)
            r = 16'sh8000;
        else
            r = sum[15:0];
        return r;
    endfunction

    pixel_t out_reg;
    pixel_t out_next;

    always_comb
    begin
        out_next.behind_viewer = behind_line_reg[QW];
        if (behind_line_reg[QW])
        begin
            out_next.screen_x = '0;
            out_next.screen_y = '0;
        end
        else
        begin
            out_next.screen_x = finish(qx, tagx, offset_x_reg);
            out_next.screen_y = finish(qy, tagy, offset_y_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result = out_reg;
    assign done   = vld_reg[NSTG-1];

endmodule

FILE: src/ptrot_checker.sv
// ----------------------------------------------------------------------------
// ptrot_checker
// port level checks of the rotate/project block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_rotate_project_macros.svh"

module ptrot_checker
    import ptrot_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   start,
    input logic   busy,
    input logic   done,
    input pixel_t result,
    input logic   cfg_valid,
    input logic   cfg_ready
);

    localparam int LAT = PIPE_LATENCY;

    logic vtx_acc;
    logic no_position;

    assign vtx_acc     = start && !busy;
    assign no_position = (result.screen_x == 16'sd0) && (result.screen_y == 16'sd0);

    // one result for each start transaction, after the fixed latency
    `PRP_ASSERT_IMP(a_latency, clk, rst_n, $past(rst_n, LAT), done == $past(vtx_acc, LAT))

    // a point behind the viewer carries no position
    `PRP_ASSERT_IMP(a_behind_zero, clk, rst_n, done && result.behind_viewer, no_position)

    // the pipeline never holds back a vertex or a register write
    `PRP_ASSERT(a_never_busy, clk, rst_n, !busy && (!cfg_valid || cfg_ready))

endmodule

bind point_rotate_project ptrot_checker u_ptrot_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for point_rotate_project: directed table of vertices
// then random ones, checked against a fixed-point predictor or a known pixel,
// the random ones under several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ptrot_pkg::*;

    localparam int N_SINE = DEF_SINE_TABLE_ENTRIES;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    vertex_t     vertex;
    logic        done;
    pixel_t      result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    point_rotate_project i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vertex    (vertex),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers and the quarter-wave table
    logic [14:0] eye_q;
    logic [11:0] scale_q;
    logic [11:0] offx_q;
    logic [11:0] offy_q;
    longint      quarter_sine [0:N_SINE];

    pixel_t pending_pixels [$];
    int     n_errors;
    int     n_vertices;
    int     n_results;
    int     n_behind;
    int     idle_count;

    // directed stimulus; a typed row carries its expected pixel
    typedef struct {
        vertex_t vtx;
        bit      typed;
        pixel_t  pix;
    } vertex_row_t;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // table built the same way as the block: taylor series in q30
    function automatic longint sine_entry(input longint k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned q;
        x    = (64'd1686629713 * k) / N_SINE;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        for (int i = 0; i < 8; i++)
        begin
            term = ((term * x2) >> 30) / ((2 * i + 2) * (2 * i + 3));
            if (i & 1)
                pos += term;
            else
                neg += term;
        end
        q = ((pos - neg) + 64'd32768) >> 16;
        if (q > 16384)
            q = 16384;
        return longint'(q);
    endfunction

    function automatic longint sine_at(input logic [15:0] phase);
        int     idx;
        longint v;
        idx = (int'(phase[13:0]) * N_SINE) >> 14;
        v   = phase[14] ? quarter_sine[N_SINE - idx] : quarter_sine[idx];
        return phase[15] ? -v : v;
    endfunction

    // round half up from q26 products back to q12 (arithmetic shift = floor)
    function automatic longint q14_round(input longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic logic [15:0] project_axis(input longint coord, input longint den,
                                                 input logic [11:0] offset);
        longint num;
        longint mag;
        longint q;
        longint r;
        num = coord * longint'(scale_q);
        mag = num < 0 ? -num : num;
        q   = (mag * 2 + den) / (den * 2);
        r   = (num < 0 ? -q : q) + longint'(offset);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic pixel_t project_vertex(input vertex_t v);
        longint s;
        longint c;
        longint x;
        longint y;
        longint z;
        longint y1;
        longint z1;
        longint x2;
        longint z2;
        longint x3;
        longint y3;
        longint den;
        pixel_t p;
        x  = v.vertex_x;
        y  = v.vertex_y;
        z  = v.vertex_z;
        s  = sine_at(v.angle_phase);
        c  = sine_at(v.angle_phase + 16'd16384);
        y1 = q14_round(c * y - s * z);
        z1 = q14_round(s * y + c * z);
        x2 = q14_round(c * x - s * z1);
        z2 = q14_round(s * x + c * z1);
        x3 = q14_round(c * x2 - s * y1);
        y3 = q14_round(s * x2 + c * y1);
        den = longint'(eye_q) - z2;
        p = '0;
        if (den <= 0)
            p.behind_viewer = 1'b1;
        else
        begin
            p.screen_x = project_axis(x3, den, offx_q);
            p.screen_y = project_axis(y3, den, offy_q);
        end
        return p;
    endfunction

    // one register write; the model copy follows the masking rules
    task automatic write_register(input logic [7:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_EYE_DISTANCE: eye_q   = data[14:0];
            REG_PIXEL_SCALE:  scale_q = data[11:0];
            REG_OFFSET_X:     offx_q  = data[11:0];
            REG_OFFSET_Y:     offy_q  = data[11:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain all expected pixels, then let the pipeline run empty
    task automatic wait_drained();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    // present one vertex; a known pixel overrides the predictor's
    task automatic send_vertex(input vertex_t v, input bit typed, input pixel_t known,
                               input int gap);
        pixel_t p;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start  <= 1'b1;
        vertex <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = typed ? known : project_vertex(v);
        pending_pixels.push_back(p);
        n_vertices++;
    endtask

    function automatic vertex_t random_vertex();
        vertex_t v;
        int mode;
        mode = $urandom_range(0, 3);
        v.vertex_x    = 16'($urandom);
        v.vertex_y    = 16'($urandom);
        v.vertex_z    = 16'($urandom);
        v.angle_phase = 16'($urandom);
        // mostly unit-sized vertices so that projections stay on screen
        if (mode != 0)
        begin
            v.vertex_x = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
            v.vertex_y = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
            v.vertex_z = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
        end
        return v;
    endfunction

    // result side: check every strobe against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel x=%0d y=%0d behind=%0b", $time,
                         result.screen_x, result.screen_y, result.behind_viewer);
                n_errors++;
            end
            else
            begin
                pixel_t want;
                want = pending_pixels.pop_front();
                if (result.screen_x !== want.screen_x)
                begin
                    $display("%0t: screen_x expected %0d actual %0d", $time,
                             want.screen_x, result.screen_x);
                    n_errors++;
                end
                if (result.screen_y !== want.screen_y)
                begin
                    $display("%0t: screen_y expected %0d actual %0d", $time,
                             want.screen_y, result.screen_y);
                    n_errors++;
                end
                if (result.behind_viewer !== want.behind_viewer)
                begin
                    $display("%0t: behind_viewer expected %0b actual %0b", $time,
                             want.behind_viewer, result.behind_viewer);
                    n_errors++;
                end
                n_behind += want.behind_viewer;
            end
            n_results++;
        end
    end

    // watchdog: cycles with no transaction of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        vertex_row_t rows [$];
        vertex_row_t r;
        logic [15:0] cfg_sets [0:4][0:3];
        int burst;

        n_errors   = 0;
        n_vertices = 0;
        n_results  = 0;
        n_behind   = 0;
        idle_count = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        vertex     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        for (int k = 0; k <= N_SINE; k++)
            quarter_sine[k] = sine_entry(k);
        eye_q   = RST_EYE_DISTANCE;
        scale_q = RST_PIXEL_SCALE;
        offx_q  = RST_OFFSET_X;
        offy_q  = RST_OFFSET_Y;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows under the reset defaults
        // origin at zero angle lands on the screen offsets
        r = '{vtx: '{16'sd0, 16'sd0, 16'sd0, 16'd0}, typed: 1, pix: '{16'sd320, 16'sd240, 1'b0}};
        rows.push_back(r);
        // x = 1.0, angle 0, d = 2.0: 200/2 = 100 pixels right
        r = '{vtx: '{16'sd4096, 16'sd0, 16'sd0, 16'd0}, typed: 1, pix: '{16'sd420, 16'sd240, 1'b0}};
        rows.push_back(r);
        // z = 2.0 meets the eye: behind the viewer, no position
        r = '{vtx: '{16'sd100, 16'sd100, 16'sd8192, 16'd0}, typed: 1, pix: '{16'sd0, 16'sd0, 1'b1}};
        rows.push_back(r);
        // field extremes and the quadrant boundaries of the phase
        foreach (rows[i]) ;
        for (int q = 0; q < 4; q++)
        begin
            r = '{vtx: '{16'sd4096, -16'sd4096, 16'sd2048, 16'(q * 16384)}, typed: 0, pix: '0};
            rows.push_back(r);
            r = '{vtx: '{16'sd4096, 16'sd4096, -16'sd4096, 16'(q * 16384 + 16383)},
                  typed: 0, pix: '0};
            rows.push_back(r);
        end
        r = '{vtx: '{16'h7fff, 16'h7fff, 16'h7fff, 16'hffff}, typed: 0, pix: '0};
        rows.push_back(r);
        r = '{vtx: '{16'h8000, 16'h8000, 16'h8000, 16'h0000}, typed: 0, pix: '0};
        rows.push_back(r);
        r = '{vtx: '{16'h8000, 16'h7fff, 16'h8000, 16'h8000}, typed: 0, pix: '0};
        rows.push_back(r);
        r = '{vtx: '{16'h7fff, 16'h8000, -16'sd32768, 16'h4000}, typed: 0, pix: '0};
        rows.push_back(r);
        r = '{vtx: '{16'hffff, 16'h0001, 16'hffff, 16'h2000}, typed: 0, pix: '0};
        rows.push_back(r);
        foreach (rows[i])
            send_vertex(rows[i].vtx, rows[i].typed, rows[i].pix, 0);
        @(negedge clk);
        start <= 1'b0;
        wait_drained();

        // register settings: extremes, defaults and fixed mid values
        cfg_sets[0] = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
        cfg_sets[1] = '{16'd0, 16'd0, 16'd0, 16'd0};
        cfg_sets[2] = '{16'd1, 16'd4095, 16'd0, 16'd4095};
        cfg_sets[3] = '{16'd16384, 16'd1000, 16'd2048, 16'd100};
        cfg_sets[4] = '{16'd8192, 16'd200, 16'd320, 16'd240};

        for (int ph = 0; ph < 5; ph++)
        begin
            write_register(REG_EYE_DISTANCE, cfg_sets[ph][0]);
            write_register(REG_PIXEL_SCALE, cfg_sets[ph][1]);
            write_register(REG_OFFSET_X, cfg_sets[ph][2]);
            write_register(REG_OFFSET_Y, cfg_sets[ph][3]);
            // an index past the last register must leave everything alone
            write_register(8'(REG_OFFSET_Y + 1 + $urandom_range(0, 250)), 16'($urandom));
            for (int n = 0; n < 200; n++)
            begin
                int gap;
                // runs of back-to-back vertices between gappy stretches
                burst = (n / 25) % 2;
                gap = burst ? 0 : $urandom_range(0, 19);
                send_vertex(random_vertex(), 0, '0, gap);
                // hold off until the pipeline is empty once per phase
                if (n == 100)
                begin
                    @(negedge clk);
                    start <= 1'b0;
                    while (pending_pixels.size() != 0)
                        @(posedge clk);
                end
            end
            @(negedge clk);
            start <= 1'b0;
            wait_drained();
        end

        $display("tb: %0d vertices, %0d pixels checked, %0d behind the viewer,",
                 n_vertices, n_results, n_behind);
        $display("tb: five register settings incl. all-zero and all-ones extremes");
        if (n_errors == 0 && pending_pixels.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: point_rotate_project.f
+incdir+src
src/ptrot_pkg.sv
src/ptrot_sincos.sv
src/ptrot_div.sv
src/point_rotate_project.sv
src/ptrot_checker.sv
dv/tb.sv
